// ===== design/sha256md_pkg.sv =====
// types and constants of the sha-256 digest core
package sha256md_pkg;

  // one transfer on the input side
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  // one transfer on the output side
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StLoad,
    StRound,
    StFin,
    StAdd,
    StOutRd,
    StOutWr
  } state_e;

  // round phases
  typedef enum logic [1:0] {
    PhReadA,
    PhReadB,
    PhSched
  } phase_e;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ===== design/sha256_message_digest_core.sv =====
// sha-256 digest core: byte gathering, padding, compression and digest readout
//
// SHA-256 over a byte stream, one message byte per input transfer. While the
// block is gathering, one byte is taken every cycle; the transfer that fills
// a 64-byte block is followed by the compression, which keeps the input
// stalled while it loads the working variables from the chain-value memory,
// runs 64 rounds (the 16-word schedule memory has two read ports and each
// round needs up to four schedule words, so a round passes through the
// phases PhReadA, PhReadB and PhSched), completes the last round and adds the
// result back into the chain value. The transfer with end_of_message set (its
// byte, if present, counts first) starts the padding, one pad byte per cycle
// outside the compressions, with one or two more compressions; then the eight
// digest words leave, word 0 first, each read from the chain-value memory
// before it is offered, and the core is ready for the next message. A
// transfer with neither a byte nor the end flag changes nothing.
module sha256_message_digest_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  sha256md_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output sha256md_pkg::out_item_t out_data_o
);

  // sigma functions of the message schedule and the round
  function automatic logic [31:0] sg0(input logic [31:0] x);
    sg0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sg1(input logic [31:0] x);
    sg1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bs0(input logic [31:0] x);
    bs0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bs1(input logic [31:0] x);
    bs1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // control state
  sha256md_pkg::state_e    state_q, state_d;
  sha256md_pkg::phase_e    phase_q, phase_d;
  logic [5:0]              rnd_q, rnd_d;
  logic [3:0]              cnt_q, cnt_d;
  logic [5:0]              pos_q, pos_d;
  logic [63:0]             bit_cnt_q, bit_cnt_d;
  logic                    padding_q, padding_d;
  logic                    first_q, first_d;
  logic                    len_q, len_d;
  logic                    pad_done_q, pad_done_d;
  logic [7:0]              chain_vld_q, chain_vld_d;
  logic                    out_valid_q, out_valid_d;

  // payload registers
  logic [23:0]             asm_q, asm_d;
  logic [31:0]             v_q [8];
  logic [31:0]             v_d [8];
  logic [31:0]             wa_q, wa_d;
  logic [31:0]             wb_q, wb_d;
  logic [31:0]             wk_q, wk_d;
  sha256md_pkg::out_item_t out_q, out_d;

  // schedule memory ports
  logic [31:0]             blk_mem [16];
  logic                    blk_we;
  logic [3:0]              blk_waddr;
  logic [31:0]             blk_wdata;
  logic                    blk_re;
  logic [3:0]              blk_ra_addr, blk_rb_addr;
  logic [31:0]             blk_ra_q, blk_rb_q;

  // chain value memory ports
  logic [31:0]             chain_mem [8];
  logic                    ch_we;
  logic [2:0]              ch_waddr;
  logic [31:0]             ch_wdata;
  logic                    ch_re;
  logic [2:0]              ch_raddr;
  logic [31:0]             ch_rdata_q;
  logic                    ch_rvld_q;
  logic [2:0]              ch_raddr_q;
  logic [31:0]             ch_rword;

  // byte placement
  logic                    put_en;
  logic [7:0]              put_byte;

  // round datapath
  logic [31:0]             t1, t2, sched_w, w_cur;
  logic [31:0]             rv [8];
  logic [2:0]              cnt_m1;

  // never-written chain entries read as the initial hash
  assign ch_rword = ch_rvld_q ? ch_rdata_q : sha256md_pkg::InitHash[ch_raddr_q];
  assign cnt_m1   = 3'(cnt_q - 4'd1);

  // one compression round on the working variables
  assign t1 = v_q[7] + bs1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + wk_q;
  assign t2 = bs0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    rv[0] = t1 + t2;
    rv[1] = v_q[0];
    rv[2] = v_q[1];
    rv[3] = v_q[2];
    rv[4] = v_q[3] + t1;
    rv[5] = v_q[4];
    rv[6] = v_q[5];
    rv[7] = v_q[6];
  end

  // schedule word from the rolling 16-word window
  assign sched_w = wa_q + sg0(wb_q) + blk_ra_q + sg1(blk_rb_q);
  assign w_cur   = (rnd_q[5:4] == 2'd0) ? wa_q : sched_w;

  assign in_ready_o  = (state_q == sha256md_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    rnd_d       = rnd_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    bit_cnt_d   = bit_cnt_q;
    padding_d   = padding_q;
    first_d     = first_q;
    len_d       = len_q;
    pad_done_d  = pad_done_q;
    chain_vld_d = chain_vld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    asm_d       = asm_q;
    v_d         = v_q;
    wa_d        = wa_q;
    wb_d        = wb_q;
    wk_d        = wk_q;
    blk_we      = 1'b0;
    blk_waddr   = pos_q[5:2];
    blk_wdata   = 32'd0;
    blk_re      = 1'b0;
    blk_ra_addr = rnd_q[3:0];
    blk_rb_addr = 4'(rnd_q[3:0] + 4'd1);
    ch_we       = 1'b0;
    ch_waddr    = cnt_m1;
    ch_wdata    = ch_rword + v_q[0];
    ch_re       = 1'b0;
    ch_raddr    = cnt_q[2:0];
    put_en      = 1'b0;
    put_byte    = 8'd0;

    unique case (state_q)
      sha256md_pkg::StIdle: begin
        if (in_valid_i) begin
          if (in_data_i.byte_present) begin
            put_en    = 1'b1;
            put_byte  = in_data_i.message_byte;
            bit_cnt_d = bit_cnt_q + 64'd8;
          end
          if (in_data_i.end_of_message) begin
            padding_d = 1'b1;
            first_d   = 1'b1;
            state_d   = sha256md_pkg::StPad;
          end
        end
      end
      sha256md_pkg::StPad: begin
        put_en  = 1'b1;
        first_d = 1'b0;
        if (first_q) begin
          put_byte = sha256md_pkg::PadByte;
        end else if (len_q || pos_q == sha256md_pkg::LenPos) begin
          put_byte = bit_cnt_q[{~pos_q[2:0], 3'b000} +: 8];
          len_d    = 1'b1;
        end
        if (len_q && pos_q == sha256md_pkg::LastPos) begin
          pad_done_d = 1'b1;
        end
      end
      sha256md_pkg::StLoad: begin
        // stream the chain value into the working variables
        ch_re = (cnt_q[3] == 1'b0);
        if (cnt_q != 4'd0) begin
          for (int i = 0; i < 7; i++) v_d[i] = v_q[i + 1];
          v_d[7] = ch_rword;
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q[3]) begin
          state_d = sha256md_pkg::StRound;
          phase_d = sha256md_pkg::PhReadA;
          rnd_d   = 6'd0;
        end
      end
      sha256md_pkg::StRound: begin
        unique case (phase_q)
          sha256md_pkg::PhReadA: begin
            // previous round completes while the next reads start
            blk_re = 1'b1;
            if (rnd_q != 6'd0) v_d = rv;
            phase_d = sha256md_pkg::PhReadB;
          end
          sha256md_pkg::PhReadB: begin
            wa_d        = blk_ra_q;
            wb_d        = blk_rb_q;
            blk_re      = 1'b1;
            blk_ra_addr = 4'(rnd_q[3:0] - 4'd7);
            blk_rb_addr = 4'(rnd_q[3:0] - 4'd2);
            phase_d     = sha256md_pkg::PhSched;
          end
          sha256md_pkg::PhSched: begin
            wk_d      = w_cur + sha256md_pkg::RoundK[rnd_q];
            blk_we    = (rnd_q[5:4] != 2'd0);
            blk_waddr = rnd_q[3:0];
            blk_wdata = w_cur;
            rnd_d     = rnd_q + 6'd1;
            phase_d   = sha256md_pkg::PhReadA;
            if (rnd_q == sha256md_pkg::LastPos) state_d = sha256md_pkg::StFin;
          end
          default: phase_d = sha256md_pkg::PhReadA;
        endcase
      end
      sha256md_pkg::StFin: begin
        v_d     = rv;
        cnt_d   = 4'd0;
        state_d = sha256md_pkg::StAdd;
      end
      sha256md_pkg::StAdd: begin
        // read-add-write the chain value, one word a cycle
        ch_re = (cnt_q[3] == 1'b0);
        if (cnt_q != 4'd0) begin
          ch_we                 = 1'b1;
          chain_vld_d[cnt_m1]   = 1'b1;
          for (int i = 0; i < 7; i++) v_d[i] = v_q[i + 1];
          v_d[7] = v_q[0];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q[3]) begin
          cnt_d = 4'd0;
          if (pad_done_q) state_d = sha256md_pkg::StOutRd;
          else if (padding_q) state_d = sha256md_pkg::StPad;
          else state_d = sha256md_pkg::StIdle;
        end
      end
      sha256md_pkg::StOutRd: begin
        ch_re   = 1'b1;
        state_d = sha256md_pkg::StOutWr;
      end
      sha256md_pkg::StOutWr: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.digest_word = ch_rword;
          out_d.word_number = cnt_q[2:0];
          out_d.last_word   = (cnt_q[2:0] == 3'd7);
          cnt_d             = cnt_q + 4'd1;
          state_d           = sha256md_pkg::StOutRd;
          if (cnt_q[2:0] == 3'd7) begin
            // back to the state after reset for the next message
            chain_vld_d = 8'd0;
            bit_cnt_d   = 64'd0;
            pos_d       = 6'd0;
            padding_d   = 1'b0;
            len_d       = 1'b0;
            pad_done_d  = 1'b0;
            cnt_d       = 4'd0;
            state_d     = sha256md_pkg::StIdle;
          end
        end
      end
      default: state_d = sha256md_pkg::StIdle;
    endcase

    // place one byte big-endian, write the word on its last lane
    if (put_en) begin
      case (pos_q[1:0])
        2'd0: asm_d[23:16] = put_byte;
        2'd1: asm_d[15:8]  = put_byte;
        2'd2: asm_d[7:0]   = put_byte;
        default: begin
          blk_we    = 1'b1;
          blk_waddr = pos_q[5:2];
          blk_wdata = {asm_q, put_byte};
        end
      endcase
      pos_d = pos_q + 6'd1;
      if (pos_q == sha256md_pkg::LastPos) begin
        cnt_d   = 4'd0;
        state_d = sha256md_pkg::StLoad;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha256md_pkg::StIdle;
      phase_q     <= sha256md_pkg::PhReadA;
      rnd_q       <= 6'd0;
      cnt_q       <= 4'd0;
      pos_q       <= 6'd0;
      bit_cnt_q   <= 64'd0;
      padding_q   <= 1'b0;
      first_q     <= 1'b0;
      len_q       <= 1'b0;
      pad_done_q  <= 1'b0;
      chain_vld_q <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rnd_q       <= rnd_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      bit_cnt_q   <= bit_cnt_d;
      padding_q   <= padding_d;
      first_q     <= first_d;
      len_q       <= len_d;
      pad_done_q  <= pad_done_d;
      chain_vld_q <= chain_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
    v_q   <= v_d;
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    wk_q  <= wk_d;
    out_q <= out_d;
  end

  // schedule memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
    if (blk_re) begin
      blk_ra_q <= blk_mem[blk_ra_addr];
      blk_rb_q <= blk_mem[blk_rb_addr];
    end
  end

  // chain value memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ch_we) chain_mem[ch_waddr] <= ch_wdata;
    if (ch_re) begin
      ch_rdata_q <= chain_mem[ch_raddr];
      ch_raddr_q <= ch_raddr;
      ch_rvld_q  <= chain_vld_q[ch_raddr];
    end
  end

  // an end transfer always stalls the input for padding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.end_of_message |=> !in_ready_o)
    else $error("input taken right after end of message");

  // chain value is only written back after a compression
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_we |-> state_q == sha256md_pkg::StAdd && cnt_q != 4'd0)
    else $error("chain value written outside the add sweep");

  // the flagged last word is always word seven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last_word |-> out_data_o.word_number == 3'd7)
    else $error("last word flag on wrong word");

  // no byte is placed while the compression rounds run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha256md_pkg::StRound |-> !put_en)
    else $error("byte placed during compression");

endmodule
